>>> hw/rtl/fsts_pkg.sv
// Shared types and constants for the floppy sector transfer sequencer.
// No dependencies; imported by every module of the block.
package fsts_pkg;

   localparam int SECTOR_BYTES = 128;
   localparam int MAX_RETRIES  = 5;

   // Shared divider: widest dividend is cs + trk * skew, below 2^22.
   localparam int DIV_W     = 22;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int CSR_AW    = 5;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STAT_ISSUE    = 3'd0,
      STAT_DONE_OK  = 3'd1,
      STAT_DONE_ERR = 3'd2,
      STAT_REJECT   = 3'd3,
      STAT_IGNORE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_SPT       = 3'd0,
      REG_SPB       = 3'd1,
      REG_TOT_SECT  = 3'd2,
      REG_TOT_BLK   = 3'd3,
      REG_INCREMENT = 3'd4,
      REG_INTERLV   = 3'd5,
      REG_SKEW      = 3'd6,
      REG_OFFSET    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [5:0]  spt;
      logic [4:0]  spb;
      logic [15:0] total_sectors;
      logic [15:0] total_blocks;
      logic [5:0]  increment;
      logic [5:0]  interleave;
      logic [5:0]  skew;
      logic [7:0]  offset;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [5:0]           divisor;
      logic [DIV_CNT_W-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [5:0]       rem;
   } div_rsp_type;

endpackage

>>> hw/rtl/fsts_csr.sv
// Configuration register file with APB-style access for the sector sequencer.
// Depends on fsts_pkg (cfg_type, register indexes).
module fsts_csr
   import fsts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;

   assign idx        = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_SPT:       cfg_in.spt           = csr_pwdata[5:0];
            REG_SPB:       cfg_in.spb           = csr_pwdata[4:0];
            REG_TOT_SECT:  cfg_in.total_sectors = csr_pwdata[15:0];
            REG_TOT_BLK:   cfg_in.total_blocks  = csr_pwdata[15:0];
            REG_INCREMENT: cfg_in.increment     = csr_pwdata[5:0];
            REG_INTERLV:   cfg_in.interleave    = csr_pwdata[5:0];
            REG_SKEW:      cfg_in.skew          = csr_pwdata[5:0];
            REG_OFFSET:    cfg_in.offset        = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SPT:       csr_prdata = {26'd0, cfg_ff.spt};
         REG_SPB:       csr_prdata = {27'd0, cfg_ff.spb};
         REG_TOT_SECT:  csr_prdata = {16'd0, cfg_ff.total_sectors};
         REG_TOT_BLK:   csr_prdata = {16'd0, cfg_ff.total_blocks};
         REG_INCREMENT: csr_prdata = {26'd0, cfg_ff.increment};
         REG_INTERLV:   csr_prdata = {26'd0, cfg_ff.interleave};
         REG_SKEW:      csr_prdata = {26'd0, cfg_ff.skew};
         REG_OFFSET:    csr_prdata = {24'd0, cfg_ff.offset};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spt           <= 6'd26;
         cfg_ff.spb           <= 5'd4;
         cfg_ff.total_sectors <= 16'd2002;
         cfg_ff.total_blocks  <= 16'd500;
         cfg_ff.increment     <= 6'd2;
         cfg_ff.interleave    <= 6'd13;
         cfg_ff.skew          <= 6'd6;
         cfg_ff.offset        <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/fsts_div.sv
// Shared restoring divider, one quotient bit per cycle, 6-bit divisor.
// Depends on fsts_pkg (div_req_type, div_rsp_type, DIV_W).
module fsts_div
   import fsts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [5:0]           rem_ff, rem_in;
   logic [5:0]           dvs_ff, dvs_in;
   logic [6:0]           trial;
   logic [6:0]           diff;
   logic                 ge;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         // left-align the dividend so only nbits iterations are needed
         run_in = 1'b1;
         cnt_in = req.nbits;
         num_in = req.dividend << (DIV_CNT_W'(DIV_W) - req.nbits);
         rem_in = 6'd0;
         dvs_in = req.divisor;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[5:0] : trial[5:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> hw/rtl/fsts_ctrl.sv
// Request sequencer: transfer state, sector mapping steps on the shared
// divider and one shared multiplier, and the result output register.
// Depends on fsts_pkg.
module fsts_ctrl
   import fsts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_block_number,
   input  logic [15:0] req_byte_count,
   input  logic        req_drive,
   input  logic        req_is_read,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_phys_track,
   output logic [7:0]  rsp_phys_sector,
   output logic        rsp_unit,
   output logic        rsp_read_op,
   output logic [7:0]  rsp_transfer_bytes,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_TRK  = 7'b0000100,
      S_POS  = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_SKEW = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        busy_ff, busy_in;
   logic        read_ff, read_in;
   logic        unit_ff, unit_in;
   logic [15:0] cur_ff, cur_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] blk_ff, blk_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [2:0]  retry_ff, retry_in;
   logic [15:0] trk_ff, trk_in;
   logic [11:0] cs_ff, cs_in;
   div_req_type div_req_ff, div_req_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_track_ff, rsp_track_in;
   logic [7:0]  rsp_sector_ff, rsp_sector_in;
   logic        rsp_unit_ff, rsp_unit_in;
   logic        rsp_read_ff, rsp_read_in;
   logic [7:0]  rsp_bytes_ff, rsp_bytes_in;

   logic [5:0]  spt_eff;
   logic [5:0]  il_eff;
   logic        slot_free;
   logic        accept;
   logic        more;
   logic [16:0] next_sect;
   logic        retry_ok;
   logic [15:0] mul_a;
   logic [5:0]  mul_b;
   logic [21:0] mul_p;
   logic [21:0] skew_sum;

   assign spt_eff   = (cfg.spt == 6'd0) ? 6'd1 : cfg.spt;
   assign il_eff    = (cfg.interleave == 6'd0) ? 6'd1 : cfg.interleave;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign more      = left_ff > 16'(SECTOR_BYTES);
   assign next_sect = {1'b0, cur_ff} + 17'd1;
   assign retry_ok  = ({1'b0, retry_ff} + 4'd1) <= 4'(MAX_RETRIES);
   assign skew_sum  = mul_p + 22'(cs_ff);

   // one multiplier, operands picked by the step in progress
   always_comb begin
      mul_a = 16'd0;
      mul_b = 6'd0;
      unique case (state_ff)
         S_LOAD: begin
            mul_a = blk_ff;
            mul_b = {1'b0, cfg.spb};
         end
         S_POS: begin
            mul_a = {10'd0, div_rsp.rem};
            mul_b = cfg.increment;
         end
         S_MUL: begin
            mul_a = trk_ff;
            mul_b = cfg.skew;
         end
         default: begin
            mul_a = 16'd0;
            mul_b = 6'd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      read_in       = read_ff;
      unit_in       = unit_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      blk_in        = blk_ff;
      bytes_in      = bytes_ff;
      retry_in      = retry_ff;
      trk_in        = trk_ff;
      cs_in         = cs_ff;
      div_req_in    = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_unit_in   = rsp_unit_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_bytes_in  = rsp_bytes_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // immediate result words carry zero payload
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_IGNORE;
               rsp_track_in  = 8'd0;
               rsp_sector_in = 8'd0;
               rsp_unit_in   = 1'b0;
               rsp_read_in   = 1'b0;
               rsp_bytes_in  = 8'd0;
               unique case (kind_type'(req_kind))
                  KIND_START: begin
                     if (busy_ff || req_block_number >= cfg.total_blocks) begin
                        rsp_status_in = STAT_REJECT;
                     end else begin
                        rsp_valid_in = 1'b0;
                        busy_in      = 1'b1;
                        blk_in       = req_block_number;
                        bytes_in     = req_byte_count;
                        unit_in      = req_drive;
                        read_in      = req_is_read;
                        retry_in     = 3'd0;
                        state_in     = S_LOAD;
                     end
                  end
                  KIND_DONE: begin
                     if (busy_ff) begin
                        left_in = more ? left_ff - 16'(SECTOR_BYTES) : 16'd0;
                        cur_in  = next_sect[15:0];
                        if (more && next_sect < {1'b0, cfg.total_sectors}) begin
                           rsp_valid_in        = 1'b0;
                           div_req_in.start    = 1'b1;
                           div_req_in.dividend = DIV_W'(next_sect[15:0]);
                           div_req_in.divisor  = spt_eff;
                           div_req_in.nbits    = DIV_CNT_W'(16);
                           state_in            = S_TRK;
                        end else begin
                           busy_in       = 1'b0;
                           retry_in      = 3'd0;
                           rsp_status_in = STAT_DONE_OK;
                        end
                     end
                  end
                  KIND_ERROR: begin
                     if (busy_ff) begin
                        if (retry_ok) begin
                           rsp_valid_in = 1'b0;
                           retry_in     = retry_ff + 3'd1;
                           state_in     = S_LOAD;
                        end else begin
                           busy_in       = 1'b0;
                           retry_in      = 3'd0;
                           rsp_status_in = STAT_DONE_ERR;
                        end
                     end
                  end
                  default: rsp_status_in = STAT_IGNORE;
               endcase
            end
         end
         S_LOAD: begin
            // first sector = block * sectors_per_block, saturated to 16 bits
            cur_in              = (mul_p > 22'h00FFFF) ? 16'hFFFF : mul_p[15:0];
            left_in             = bytes_ff;
            div_req_in.start    = 1'b1;
            div_req_in.dividend = DIV_W'(cur_in);
            div_req_in.divisor  = spt_eff;
            div_req_in.nbits    = DIV_CNT_W'(16);
            state_in            = S_TRK;
         end
         S_TRK: begin
            if (div_rsp.done) begin
               trk_in              = div_rsp.quot[15:0];
               div_req_in.start    = 1'b1;
               div_req_in.dividend = DIV_W'(div_rsp.rem);
               div_req_in.divisor  = il_eff;
               div_req_in.nbits    = DIV_CNT_W'(6);
               state_in            = S_POS;
            end
         end
         S_POS: begin
            if (div_rsp.done) begin
               cs_in    = mul_p[11:0] + {6'd0, div_rsp.quot[5:0]};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (cfg.skew != 6'd0) begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = skew_sum;
               div_req_in.divisor  = spt_eff;
               div_req_in.nbits    = DIV_CNT_W'(DIV_W);
               state_in            = S_SKEW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SKEW: begin
            if (div_rsp.done) begin
               cs_in    = {6'd0, div_rsp.rem};
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_ISSUE;
               rsp_track_in  = trk_ff[7:0] + cfg.offset;
               rsp_sector_in = cs_ff[7:0] + 8'd1;
               rsp_unit_in   = unit_ff;
               rsp_read_in   = read_ff;
               rsp_bytes_in  = (left_ff < 16'(SECTOR_BYTES)) ? left_ff[7:0]
                                                              : 8'(SECTOR_BYTES);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         read_ff      <= 1'b0;
         unit_ff      <= 1'b0;
         cur_ff       <= 16'd0;
         left_ff      <= 16'd0;
         blk_ff       <= 16'd0;
         bytes_ff     <= 16'd0;
         retry_ff     <= 3'd0;
         div_req_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         read_ff      <= read_in;
         unit_ff      <= unit_in;
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         blk_ff       <= blk_in;
         bytes_ff     <= bytes_in;
         retry_ff     <= retry_in;
         div_req_ff   <= div_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trk_ff        <= trk_in;
      cs_ff         <= cs_in;
      rsp_status_ff <= rsp_status_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_unit_ff   <= rsp_unit_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   assign div_req            = div_req_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_phys_track     = rsp_track_ff;
   assign rsp_phys_sector    = rsp_sector_ff;
   assign rsp_unit           = rsp_unit_ff;
   assign rsp_read_op        = rsp_read_ff;
   assign rsp_transfer_bytes = rsp_bytes_ff;

   a_work_needs_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> busy_ff)
      else $error("mapping sequence running without an active request");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_TRK || state_ff == S_POS || state_ff == S_SKEW))
      else $error("divider finished outside a wait step");

   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      retry_ff <= 3'(MAX_RETRIES))
      else $error("retry count past limit");

   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_ISSUE |->
         rsp_track_ff == 8'd0 && rsp_sector_ff == 8'd0 && !rsp_unit_ff &&
         !rsp_read_ff && rsp_bytes_ff == 8'd0)
      else $error("non-issue word with nonzero payload");

   a_issue_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_ISSUE |->
         rsp_bytes_ff <= 8'(SECTOR_BYTES))
      else $error("issued transfer longer than a sector");

endmodule

>>> hw/rtl/floppy_sector_transfer_sequencer.sv
// Floppy sector transfer sequencer. Done, error-fail, reject and ignore words
// come back in the cycle after the input word is taken. An issued sector is
// mapped after a start or retry word by a multiply step and then shared-divider
// steps (track, interleave position and, with skew on, skew), and after a done
// word without the multiply step; one input word is in work at a time.
// Synchronous active-high reset: idle, no result pending, registers at defaults.
module floppy_sector_transfer_sequencer
   import fsts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [15:0]       req_block_number,
   input  logic [15:0]       req_byte_count,
   input  logic              req_drive,
   input  logic              req_is_read,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_phys_track,
   output logic [7:0]        rsp_phys_sector,
   output logic              rsp_unit,
   output logic              rsp_read_op,
   output logic [7:0]        rsp_transfer_bytes,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   fsts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fsts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fsts_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_block_number   (req_block_number),
      .req_byte_count     (req_byte_count),
      .req_drive          (req_drive),
      .req_is_read        (req_is_read),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_phys_track     (rsp_phys_track),
      .rsp_phys_sector    (rsp_phys_sector),
      .rsp_unit           (rsp_unit),
      .rsp_read_op        (rsp_read_op),
      .rsp_transfer_bytes (rsp_transfer_bytes),
      .div_req            (div_req),
      .div_rsp            (div_rsp)
   );

endmodule
